// ===== rtl/scfl_pkg.sv =====
package scfl_pkg;

	// Command codes of an input item
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_RESIZE  = 2'd2;

	// Configuration register indexes (word address bit 2)
	localparam logic CFG_IDX_LIMIT = 1'b0;

	localparam logic [6:0] LIMIT_RESET = 7'd64;

	// Widest class index over the supported parameter range
	localparam int CLS_FIELD_W = 16;

	typedef enum logic [2:0] {
		ACT_CACHED_HIT    = 3'd0,
		ACT_FWD_ALLOC     = 3'd1,
		ACT_CACHED_FREE   = 3'd2,
		ACT_FWD_FREE      = 3'd3,
		ACT_KEEP          = 3'd4,
		ACT_FWD_REALLOC   = 3'd5,
		ACT_COPY          = 3'd6,
		ACT_IGNORED       = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		OP_ALLOC       = 3'd0,
		OP_FREE        = 3'd1,
		OP_KEEP        = 3'd2,
		OP_FWD_REALLOC = 3'd3,
		OP_MOVE        = 3'd4,
		OP_IGNORE      = 3'd5
	} op_kind_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] block_address;
		logic [31:0] size;
		logic [31:0] old_size;
	} req_t;

	typedef struct packed {
		action_t     action;
		logic [63:0] result_address;
		logic [31:0] result_size;
		logic        last;
	} res_t;

	// Classified operation handed from the front end to the back end
	typedef struct packed {
		op_kind_t                kind;
		logic [63:0]             addr;
		logic [31:0]             new_size;
		logic [31:0]             copy_len;
		logic                    new_hit;
		logic [CLS_FIELD_W-1:0]  new_cls;
		logic                    old_hit;
		logic [CLS_FIELD_W-1:0]  old_cls;
	} op_t;

endpackage

// ===== rtl/scfl_ram.sv =====
module scfl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/scfl_fifo.sv =====
module scfl_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/scfl_front.sv =====
module scfl_front import scfl_pkg::*; #(
	parameter int CLASS_STEP     = 16,
	parameter int MAX_SMALL_SIZE = 1024,
	parameter int ADDR_WIDTH     = 64
) (
	input  req_t request,
	input  logic push,
	output logic full,
	input  logic clearing,
	output logic op_push,
	output op_t  op_data,
	input  logic op_full
);

	localparam int NUM_CLASSES = (MAX_SMALL_SIZE + CLASS_STEP - 1) / CLASS_STEP;
	localparam int CLS_W = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
	// (size - 1) / CLASS_STEP by an exact round-up reciprocal
	localparam int SZ_W  = MAX_SMALL_SIZE > 2 ? $clog2(MAX_SMALL_SIZE) : 1;
	localparam int SH    = SZ_W + $clog2(CLASS_STEP);
	localparam int M_W   = SZ_W + 2;
	localparam int P_W   = SZ_W + M_W;
	localparam logic [M_W-1:0] RECIP =
		M_W'(((64'd1 << SH) + 64'(CLASS_STEP) - 64'd1) / 64'(CLASS_STEP));
	localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_WIDTH);

	// Returns {hit, class}
	function automatic logic [CLS_W:0] class_of(input logic [31:0] sz);
		logic [SZ_W-1:0] v;
		logic [P_W-1:0]  prod;
		logic            hit;
		v    = SZ_W'(sz - 32'd1);
		prod = P_W'(v) * P_W'(RECIP);
		hit  = (sz != 32'd0) && (sz <= 32'(MAX_SMALL_SIZE));
		return {hit, CLS_W'(prod >> SH)};
	endfunction

	logic [31:0]    free_size;
	logic [CLS_W:0] new_c;
	logic [CLS_W:0] old_c;
	logic [63:0]    addr;
	logic           addr_null;

	assign full    = op_full || clearing;
	assign op_push = push && !full;

	assign addr      = request.block_address & ADDR_MASK;
	assign addr_null = (addr == 64'd0);
	assign free_size = (request.command == CMD_RELEASE) ? request.size : request.old_size;
	assign new_c     = class_of(request.size);
	assign old_c     = class_of(free_size);

	always_comb begin
		op_data          = '0;
		op_data.addr     = addr;
		op_data.new_size = request.size;
		op_data.copy_len = (request.old_size < request.size) ? request.old_size : request.size;
		op_data.new_hit  = new_c[CLS_W];
		op_data.new_cls  = CLS_FIELD_W'(new_c[CLS_W-1:0]);
		op_data.old_hit  = old_c[CLS_W];
		op_data.old_cls  = CLS_FIELD_W'(old_c[CLS_W-1:0]);
		op_data.kind     = OP_IGNORE;
		case (request.command)
			CMD_ALLOC: begin
				op_data.kind = OP_ALLOC;
			end
			CMD_RELEASE: begin
				op_data.kind = addr_null ? OP_IGNORE : OP_FREE;
			end
			CMD_RESIZE: begin
				if (addr_null) begin
					op_data.kind = OP_ALLOC;
				end else if (request.size == 32'd0) begin
					op_data.kind = OP_FREE;
				end else if (old_c[CLS_W] && new_c[CLS_W] && old_c == new_c) begin
					op_data.kind = OP_KEEP;
				end else if (!old_c[CLS_W] && !new_c[CLS_W]) begin
					op_data.kind = OP_FWD_REALLOC;
				end else begin
					op_data.kind = OP_MOVE;
				end
			end
			default: begin
				op_data.kind = OP_IGNORE;
			end
		endcase
	end

endmodule

// ===== rtl/scfl_back.sv =====
module scfl_back import scfl_pkg::*; #(
	parameter int CLASS_STEP     = 16,
	parameter int MAX_SMALL_SIZE = 1024,
	parameter int STACK_DEPTH    = 64,
	parameter int ADDR_WIDTH     = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] limit,
	output logic       clearing,
	input  op_t        op_rdata,
	input  logic       op_empty,
	output logic       op_pop,
	input  logic       out_full,
	output logic       out_push,
	output res_t       out_item
);

	localparam int NUM_CLASSES = (MAX_SMALL_SIZE + CLASS_STEP - 1) / CLASS_STEP;
	localparam int CLS_W  = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
	localparam int MEM_D  = NUM_CLASSES * STACK_DEPTH;
	localparam int MEM_AW = MEM_D > 1 ? $clog2(MEM_D) : 1;
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W  = CNT_W > 7 ? CNT_W : 7;

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_PREP    = 8'b0000_0100,
		ST_A_CNT   = 8'b0000_1000,
		ST_A_POP   = 8'b0001_0000,
		ST_COPY    = 8'b0010_0000,
		ST_F_START = 8'b0100_0000,
		ST_F_CNT   = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [CLS_W-1:0]  clr_idx_q;
	op_t               op_q;
	logic [MEM_AW-1:0] new_base_q;
	logic [MEM_AW-1:0] old_base_q;
	logic [31:0]       round_q;

	logic [CLS_W-1:0]  new_cls;
	logic [CLS_W-1:0]  old_cls;
	logic              is_move;
	logic              emit;
	logic              fired;
	logic              room;

	logic              cnt_we;
	logic [CLS_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;
	logic              cnt_re;
	logic [CLS_W-1:0]  cnt_raddr;
	logic [CNT_W-1:0]  cnt_rdata;
	logic              stk_we;
	logic [MEM_AW-1:0] stk_waddr;
	logic              stk_re;
	logic [MEM_AW-1:0] stk_raddr;
	logic [ADDR_WIDTH-1:0] stk_rdata;

	assign new_cls  = op_q.new_cls[CLS_W-1:0];
	assign old_cls  = op_q.old_cls[CLS_W-1:0];
	assign is_move  = (op_q.kind == OP_MOVE);
	assign clearing = (state_q == ST_CLEAR);
	assign fired    = !out_full;
	assign out_push = emit && !out_full;
	assign stk_waddr = old_base_q + MEM_AW'(cnt_rdata);

	// Room in the class: below both the register limit and the stack depth
	assign room = (CMP_W'(cnt_rdata) < CMP_W'(limit)) &&
		(cnt_rdata < CNT_W'(STACK_DEPTH));

	scfl_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_CLASSES)
	) u_counts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	scfl_ram #(
		.WIDTH(ADDR_WIDTH),
		.DEPTH(MEM_D)
	) u_stacks (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (op_q.addr[ADDR_WIDTH-1:0]),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_comb begin
		state_d   = state_q;
		op_pop    = 1'b0;
		emit      = 1'b0;
		out_item  = '0;
		cnt_we    = 1'b0;
		cnt_waddr = new_cls;
		cnt_wdata = '0;
		cnt_re    = 1'b0;
		cnt_raddr = new_cls;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_raddr = new_base_q + MEM_AW'(CNT_W'(cnt_rdata - CNT_W'(1)));
		case (state_q)
			ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_idx_q;
				if (clr_idx_q == CLS_W'(NUM_CLASSES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!op_empty) begin
					op_pop  = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				case (op_q.kind)
					OP_ALLOC, OP_MOVE: begin
						if (op_q.new_hit) begin
							cnt_re  = 1'b1;
							state_d = ST_A_CNT;
						end else begin
							emit                 = 1'b1;
							out_item.action      = ACT_FWD_ALLOC;
							out_item.result_size = op_q.new_size;
							out_item.last        = !is_move;
							if (fired) begin
								state_d = is_move ? ST_COPY : ST_IDLE;
							end
						end
					end
					OP_FREE: begin
						state_d = ST_F_START;
					end
					OP_KEEP: begin
						emit                    = 1'b1;
						out_item.action         = ACT_KEEP;
						out_item.result_address = op_q.addr;
						out_item.last           = 1'b1;
						if (fired) begin
							state_d = ST_IDLE;
						end
					end
					OP_FWD_REALLOC: begin
						emit                    = 1'b1;
						out_item.action         = ACT_FWD_REALLOC;
						out_item.result_address = op_q.addr;
						out_item.result_size    = op_q.new_size;
						out_item.last           = 1'b1;
						if (fired) begin
							state_d = ST_IDLE;
						end
					end
					default: begin
						emit            = 1'b1;
						out_item.action = ACT_IGNORED;
						out_item.last   = 1'b1;
						if (fired) begin
							state_d = ST_IDLE;
						end
					end
				endcase
			end
			ST_A_CNT: begin
				if (cnt_rdata != '0) begin
					// pop: fetch the top entry and drop the count
					stk_re    = 1'b1;
					cnt_we    = 1'b1;
					cnt_wdata = CNT_W'(cnt_rdata - CNT_W'(1));
					state_d   = ST_A_POP;
				end else begin
					emit                 = 1'b1;
					out_item.action      = ACT_FWD_ALLOC;
					out_item.result_size = round_q;
					out_item.last        = !is_move;
					if (fired) begin
						state_d = is_move ? ST_COPY : ST_IDLE;
					end
				end
			end
			ST_A_POP: begin
				emit                    = 1'b1;
				out_item.action         = ACT_CACHED_HIT;
				out_item.result_address = 64'(stk_rdata);
				out_item.last           = !is_move;
				if (fired) begin
					state_d = is_move ? ST_COPY : ST_IDLE;
				end
			end
			ST_COPY: begin
				emit                    = 1'b1;
				out_item.action         = ACT_COPY;
				out_item.result_address = op_q.addr;
				out_item.result_size    = op_q.copy_len;
				if (fired) begin
					state_d = ST_F_START;
				end
			end
			ST_F_START: begin
				if (op_q.old_hit) begin
					cnt_re    = 1'b1;
					cnt_raddr = old_cls;
					state_d   = ST_F_CNT;
				end else begin
					emit                    = 1'b1;
					out_item.action         = ACT_FWD_FREE;
					out_item.result_address = op_q.addr;
					out_item.last           = 1'b1;
					if (fired) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_F_CNT: begin
				emit                    = 1'b1;
				out_item.result_address = op_q.addr;
				out_item.last           = 1'b1;
				out_item.action         = room ? ACT_CACHED_FREE : ACT_FWD_FREE;
				if (fired) begin
					state_d = ST_IDLE;
					if (room) begin
						stk_we    = 1'b1;
						cnt_we    = 1'b1;
						cnt_waddr = old_cls;
						cnt_wdata = CNT_W'(cnt_rdata + CNT_W'(1));
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op_rdata;
		end
		// stack bases and rounded size, ready for the states that follow
		if (state_q == ST_PREP) begin
			new_base_q <= MEM_AW'(MEM_AW'(new_cls) * MEM_AW'(STACK_DEPTH));
			old_base_q <= MEM_AW'(MEM_AW'(old_cls) * MEM_AW'(STACK_DEPTH));
			round_q    <= 32'((32'(new_cls) + 32'd1) * 32'(CLASS_STEP));
		end
	end

endmodule

// ===== rtl/size_class_free_list_cache.sv =====
// Size-class free-list cache, front end of a block allocator.
// Requests enter through a queue-style port: an item is taken when push is
// high and full is low. Results leave the same way: the oldest result sits on
// result while empty is low and is taken when pop is high. Each request gives
// one to three results; the final one carries last.
// The front end classifies a request in the cycle it is accepted and places it
// in a two-entry operation queue, so requests are taken while the back end
// works. The back end runs one operation at a time through a per-class count
// memory and the stack memory, both with registered reads. Keep, forward
// realloc, ignored and out-of-range allocate or release give their result from
// the operation alone; an in-range allocate or release first reads the class
// count, and a cached hit then reads the stack; a resize that moves the block
// runs allocate, copy and release in turn.
// Results go to a two-entry output queue; when it is full the back end holds
// its state and the operation queue fills, after which full rises.
// After reset the count memory is cleared, one class per cycle; full stays
// high during that pass.
// class_cache_limit is written through the APB port at byte address 0.
module size_class_free_list_cache import scfl_pkg::*; #(
	parameter int CLASS_STEP     = 16,
	parameter int MAX_SMALL_SIZE = 1024,
	parameter int STACK_DEPTH    = 64,
	parameter int ADDR_WIDTH     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  req_t        request,
	output logic        empty,
	input  logic        pop,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0] limit_q;
	logic       clearing;
	logic       op_push;
	op_t        op_wdata;
	logic       op_full;
	op_t        op_rdata;
	logic       op_empty;
	logic       op_pop;
	logic       out_push;
	res_t       out_item;
	logic       out_full;

	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == CFG_IDX_LIMIT) ? {25'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2:2] == CFG_IDX_LIMIT) begin
			limit_q <= pwdata[6:0];
		end
	end

	scfl_front #(
		.CLASS_STEP     (CLASS_STEP),
		.MAX_SMALL_SIZE (MAX_SMALL_SIZE),
		.ADDR_WIDTH     (ADDR_WIDTH)
	) u_front (
		.request  (request),
		.push     (push),
		.full     (full),
		.clearing (clearing),
		.op_push  (op_push),
		.op_data  (op_wdata),
		.op_full  (op_full)
	);

	scfl_fifo #(
		.item_t (op_t),
		.DEPTH  (2)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_wdata),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_rdata),
		.empty  (op_empty)
	);

	scfl_back #(
		.CLASS_STEP     (CLASS_STEP),
		.MAX_SMALL_SIZE (MAX_SMALL_SIZE),
		.STACK_DEPTH    (STACK_DEPTH),
		.ADDR_WIDTH     (ADDR_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit_q),
		.clearing (clearing),
		.op_rdata (op_rdata),
		.op_empty (op_empty),
		.op_pop   (op_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_item (out_item)
	);

	scfl_fifo #(
		.item_t (res_t),
		.DEPTH  (2)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
